@@ sv/frpt_pkg.sv @@
package frpt_pkg;

   // tracker capacity and bitmap geometry
   localparam int PACKETS_MAX = 4096;
   localparam int MAP_WORDS   = (PACKETS_MAX + 31) / 32;
   localparam int ROW_BITS    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   // request modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_DATA  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   localparam logic [7:0] FILE_TYPE_ACCEPT = 8'd2;
   localparam logic [7:0] TIMEOUT_RESET    = 8'd10;
   localparam logic [7:0] IDLE_TICKS_MAX   = 8'd255;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  file_type;
      logic [12:0] pack_count;
      logic [2:0]  size_code;
      logic [15:0] pack_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [25:0] write_offset;
      logic [12:0] received_count;
      logic        complete;
      logic        timed_out;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load_rsp;
      logic do_start;
      logic do_data;
      logic do_tick;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       receiving;
      logic       type_ok;
   } stat_type;

   // packet size in bytes by size code
   function automatic logic [10:0] packet_bytes(input logic [2:0] code);
      logic [10:0] bytes;
      unique case (code)
         3'd0:    bytes = 11'd64;
         3'd1:    bytes = 11'd128;
         3'd2:    bytes = 11'd256;
         3'd4:    bytes = 11'd512;
         3'd5:    bytes = 11'd1024;
         default: bytes = 11'd0;
      endcase
      return bytes;
   endfunction

endpackage

@@ sv/frpt_ctrl.sv @@
module frpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  frpt_pkg::stat_type stat,
   output frpt_pkg::cmd_type  cmd
);
   import frpt_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = req_valid && req_ready;
      cmd.load_rsp = (state_ff == ST_EXEC);
      if (state_ff == ST_EXEC) begin
         cmd.do_start = (stat.mode == MODE_START) && !stat.receiving && stat.type_ok;
         cmd.do_data  = (stat.mode == MODE_DATA) && stat.receiving;
         cmd.do_tick  = (stat.mode == MODE_TICK) && stat.receiving;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/frpt_dp.sv @@
module frpt_dp (
   input  logic               clock,
   input  logic               reset,
   input  frpt_pkg::req_type  req_data,
   input  logic               csr_write,
   input  logic [7:0]         csr_data,
   input  frpt_pkg::cmd_type  cmd,
   output frpt_pkg::stat_type stat,
   output frpt_pkg::rsp_type  rsp_data
);
   import frpt_pkg::*;

   // bitmap storage, one row per 32 packets
   logic [31:0] map_mem [MAP_WORDS];
   logic [31:0] map_rd_ff;
   logic [MAP_WORDS-1:0] row_valid_ff, row_valid_in;

   req_type     item_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        receiving_ff, receiving_in;
   logic [12:0] total_ff, total_in;
   logic [2:0]  size_ff, size_in;
   logic [12:0] seen_ff, seen_in;
   logic [7:0]  idle_ff, idle_in;
   logic [7:0]  timeout_ff;

   logic [ROW_BITS-1:0] rd_row, row;
   logic [4:0]  bit_sel;
   logic [31:0] row_data, row_wr;
   logic        in_range, is_new, map_write;
   logic [25:0] product;
   logic [12:0] seen_next;
   logic [7:0]  idle_next;
   logic [12:0] count_sat;

   assign rd_row   = req_data.pack_index[ROW_BITS+4:5];
   assign row      = item_ff.pack_index[ROW_BITS+4:5];
   assign bit_sel  = item_ff.pack_index[4:0];
   assign row_data = row_valid_ff[row] ? map_rd_ff : 32'd0;
   assign in_range = (item_ff.pack_index < {3'd0, total_ff})
                  && (32'(item_ff.pack_index) < PACKETS_MAX);
   assign is_new    = in_range && !row_data[bit_sel];
   assign row_wr    = row_data | (32'd1 << bit_sel);
   assign map_write = cmd.do_data && in_range;
   assign seen_next = is_new ? seen_ff + 13'd1 : seen_ff;
   assign idle_next = (idle_ff < IDLE_TICKS_MAX) ? idle_ff + 8'd1 : idle_ff;
   // largest index times largest size still fits in 26 bits
   assign product   = 26'(item_ff.pack_index) * 26'(packet_bytes(size_ff));
   assign count_sat = (32'(item_ff.pack_count) > PACKETS_MAX)
                    ? 13'(PACKETS_MAX) : item_ff.pack_count;

   assign stat.mode      = item_ff.mode;
   assign stat.receiving = receiving_ff;
   assign stat.type_ok   = (item_ff.file_type == FILE_TYPE_ACCEPT);
   assign rsp_data       = rsp_ff;

   always_comb begin
      receiving_in = receiving_ff;
      total_in     = total_ff;
      size_in      = size_ff;
      seen_in      = seen_ff;
      idle_in      = idle_ff;
      row_valid_in = row_valid_ff;
      rsp_in                = '0;
      rsp_in.status         = STATUS_REJECT;
      rsp_in.received_count = seen_ff;
      if (cmd.do_start) begin
         // new transfer: all rows read as empty again
         row_valid_in  = '0;
         total_in      = count_sat;
         size_in       = item_ff.size_code;
         seen_in       = 13'd0;
         idle_in       = 8'd0;
         receiving_in  = 1'b1;
         rsp_in.status = STATUS_OK;
         rsp_in.received_count = 13'd0;
      end else if (cmd.do_data) begin
         idle_in             = 8'd0;
         seen_in             = seen_next;
         rsp_in.write_offset = product;
         rsp_in.status       = in_range ? STATUS_OK : STATUS_RANGE;
         rsp_in.received_count = seen_next;
         if (map_write) begin
            row_valid_in[row] = 1'b1;
         end
         if (seen_next >= total_ff) begin
            rsp_in.complete = 1'b1;
            receiving_in    = 1'b0;
         end
      end else if (cmd.do_tick) begin
         idle_in       = idle_next;
         rsp_in.status = STATUS_OK;
         if (idle_next >= timeout_ff) begin
            rsp_in.timed_out = 1'b1;
            receiving_in     = 1'b0;
            idle_in          = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      map_rd_ff <= map_mem[rd_row];
      if (map_write) begin
         map_mem[row] <= row_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         receiving_ff <= 1'b0;
         total_ff     <= 13'd0;
         size_ff      <= 3'd0;
         seen_ff      <= 13'd0;
         idle_ff      <= 8'd0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         row_valid_ff <= row_valid_in;
         receiving_ff <= receiving_in;
         total_ff     <= total_in;
         size_ff      <= size_in;
         seen_ff      <= seen_in;
         idle_ff      <= idle_in;
         if (csr_write) begin
            timeout_ff <= csr_data;
         end
      end
   end

endmodule

@@ sv/file_packet_receive_tracker.sv @@
// packet receive tracker with inactivity timeout. every request item (start,
// data packet or timer tick) yields exactly one response item. the accept
// cycle issues the bitmap row read, the next cycle does the read-modify-write
// of that row and loads the response register, which frees the input side:
// with a ready sink a new item is taken once the last has loaded its
// response, never while one executes. the bitmap sits in a memory with one
// read and one write port, one 32-bit row per 32 packets; per-row valid
// flags make a start (and reset) clear it at once, so there is no clearing
// pass. csr_ready is always high. the user is to write the timeout register
// through the csr port only while the block is idle; it is not enforced.
module file_packet_receive_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  frpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output frpt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import frpt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // configuration writes never stall
   assign csr_ready = 1'b1;

   // sequencing and response handshake
   frpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap memory, transfer state and response register
   frpt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/frpt_checker.sv @@
module frpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input frpt_pkg::rsp_type rsp_data
);
   import frpt_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every accepted item is answered after its execute state, with no response and no new accept while it executes
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready ##1 rsp_valid)
      else $error("response timing broken");

   // a rejected item has no side results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_REJECT |->
         rsp_data.write_offset == 26'd0 && !rsp_data.complete && !rsp_data.timed_out)
      else $error("rejected item with results");

   // timeout only from a tick, never together with completion
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |->
         rsp_data.status == STATUS_OK && !rsp_data.complete
         && rsp_data.write_offset == 26'd0)
      else $error("bad timeout response");

endmodule

bind file_packet_receive_tracker frpt_checker u_frpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
